FILE: hdl/sha1md_pkg.sv
// shared types, constants and state codes for the sha1 message digest block
package sha1md_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned HASH_WORDS  = 5;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned ROUNDS      = 80;
    localparam int unsigned COUNT_W     = 61;

    localparam logic [6:0] ROUND_LAST   = 7'd79;
    localparam logic [5:0] POS_LAST     = 6'd63;
    localparam logic [5:0] POS_PRE_LEN  = 6'd55;
    localparam logic [1:0] WORD_END     = 2'd3;
    localparam logic [2:0] IDX_LAST     = 3'd4;
    localparam logic [7:0] PAD_MARK     = 8'h80;

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    localparam logic [HASH_WORDS-1:0][31:0] H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       has_byte;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_ADD,
        S_PAD,
        S_OUT
    } t_state;

    // controls for the block buffer / message schedule
    typedef struct packed {
        logic       push;
        logic       word_end;
        logic [7:0] data;
        logic       step;
    } t_sched_ctl;

    // controls for the round unit and chaining words
    typedef struct packed {
        logic       init;
        logic       load;
        logic       round;
        logic       add;
        logic [6:0] rnd;
        logic [2:0] sel;
    } t_core_ctl;

endpackage

FILE: hdl/sha1md_sched.sv
// block buffer: packs bytes into words and expands the message schedule
module sha1md_sched
    import sha1md_pkg::*;
(
    input  logic        i_clk,
    input  t_sched_ctl  i_ctl,
    output logic [31:0] o_w
);

    logic [23:0] r_acc;
    logic [BLOCK_WORDS-1:0][31:0] r_w;
    logic [31:0] w_mix;

    // next schedule word from taps t, t+2, t+8, t+13
    assign w_mix = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign o_w   = r_w[0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_acc <= {r_acc[15:0], i_ctl.data};
            if (i_ctl.word_end) begin
                r_w <= {{r_acc, i_ctl.data}, r_w[BLOCK_WORDS-1:1]};
            end
        end else if (i_ctl.step) begin
            r_w <= {{w_mix[30:0], w_mix[31]}, r_w[BLOCK_WORDS-1:1]};
        end
    end

endmodule

FILE: hdl/sha1md_core.sv
// shared round unit with working variables and chaining words
module sha1md_core
    import sha1md_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_core_ctl   i_ctl,
    input  logic [31:0] i_w,
    output logic [31:0] o_word
);

    logic [HASH_WORDS-1:0][31:0] r_h;
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] f_val, k_val, sum;

    always_comb begin
        if (i_ctl.rnd < 7'd20) begin
            f_val = r_d ^ (r_b & (r_c ^ r_d));
            k_val = K_0;
        end else if (i_ctl.rnd < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_1;
        end else if (i_ctl.rnd < 7'd60) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = K_2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_3;
        end
        sum = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + i_w;
    end

    assign o_word = r_h[i_ctl.sel];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= H_INIT;
        end else if (i_ctl.init) begin
            r_h <= H_INIT;
        end else if (i_ctl.add) begin
            r_h[0] <= r_h[0] + r_a;
            r_h[1] <= r_h[1] + r_b;
            r_h[2] <= r_h[2] + r_c;
            r_h[3] <= r_h[3] + r_d;
            r_h[4] <= r_h[4] + r_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_ctl.round) begin
            r_a <= sum;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

endmodule

FILE: hdl/sha1_message_digest_top.sv
// sha1 message digest: byte input channel, five-word digest output channel
//
// input channel: one message byte per transfer with has_byte and is_last
// flags; a transfer with is_last and no byte ends the message (empty
// message allowed). an item with neither flag changes nothing.
// output channel: five transfers per message, h0 first, word_index 0..4,
// last_word set on the fifth word.
// timing: a byte is taken on each valid transfer while the block buffer
// fills. the 64th byte of a block starts compression: 80 rounds of the
// shared round unit (one round per cycle) and then the chaining add,
// during which o_in_stall stays high. after the last item the sequencer
// inserts padding one byte per cycle (0x80, zeros, 64-bit bit length)
// to the end of the block, compresses one or two padded blocks, then
// presents the digest words on the output channel.
// o_in_stall is high from the accepted last item until the fifth digest
// word has transferred; a stalled output holds its word until taken.
// reset (synchronous, active low) restores the initial chaining values,
// clears the byte position and byte count and returns to idle.
module sha1_message_digest_top
    import sha1md_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_state              r_state, n_state;
    logic [5:0]          r_pos, n_pos;         // next byte slot in block
    logic [COUNT_W-1:0]  r_count, n_count;     // message bytes modulo 2^61
    logic [6:0]          r_t, n_t;             // round number
    logic                r_final, n_final;     // message ended, padding owed
    logic                r_first, n_first;     // next pad byte is the marker
    logic                r_len, n_len;         // pad bytes are now the length
    logic                r_done, n_done;       // last padded block compressing
    logic [2:0]          r_idx, n_idx;         // digest word being shown

    t_sched_ctl  sctl;
    t_core_ctl   cctl;
    logic [31:0] w_cur;
    logic [31:0] h_word;
    logic [63:0] bit_len;
    logic [7:0]  len_byte;

    sha1md_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (sctl),
        .o_w   (w_cur)
    );

    sha1md_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cctl),
        .i_w     (w_cur),
        .o_word  (h_word)
    );

    // length bytes go out most significant first, one per slot 56..63
    assign bit_len  = {r_count, 3'b000};
    assign len_byte = 8'(bit_len >> {~r_pos[2:0], 3'b000});

    assign o_in_stall             = (r_state != S_IDLE);
    assign o_out_valid            = (r_state == S_OUT);
    assign o_out_item.digest_word = h_word;
    assign o_out_item.word_index  = r_idx;
    assign o_out_item.last_word   = (r_idx == IDX_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_count <= '0;
            r_t     <= '0;
            r_final <= 1'b0;
            r_first <= 1'b0;
            r_len   <= 1'b0;
            r_done  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_count <= n_count;
            r_t     <= n_t;
            r_final <= n_final;
            r_first <= n_first;
            r_len   <= n_len;
            r_done  <= n_done;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_count = r_count;
        n_t     = r_t;
        n_final = r_final;
        n_first = r_first;
        n_len   = r_len;
        n_done  = r_done;
        n_idx   = r_idx;

        sctl          = '0;
        sctl.word_end = (r_pos[1:0] == WORD_END);
        cctl          = '0;
        cctl.rnd      = r_t;
        cctl.sel      = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_item.has_byte) begin
                        sctl.push = 1'b1;
                        sctl.data = i_in_item.msg_byte;
                        n_pos     = r_pos + 6'd1;
                        n_count   = r_count + COUNT_W'(1);
                    end
                    if (i_in_item.is_last) begin
                        n_final = 1'b1;
                        n_first = 1'b1;
                    end
                    if (i_in_item.has_byte && r_pos == POS_LAST) begin
                        // block full: start compression
                        n_state   = S_ROUND;
                        cctl.load = 1'b1;
                        n_t       = '0;
                    end else if (i_in_item.is_last) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_ROUND: begin
                cctl.round = 1'b1;
                sctl.step  = 1'b1;
                n_t        = r_t + 7'd1;
                if (r_t == ROUND_LAST) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                cctl.add = 1'b1;
                if (!r_final) begin
                    n_state = S_IDLE;
                end else if (r_done) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_PAD: begin
                sctl.push = 1'b1;
                sctl.data = r_first ? PAD_MARK : (r_len ? len_byte : 8'h00);
                n_first   = 1'b0;
                n_pos     = r_pos + 6'd1;
                if (r_pos == POS_PRE_LEN) begin
                    n_len = 1'b1;
                end
                if (r_pos == POS_LAST) begin
                    n_state   = S_ROUND;
                    cctl.load = 1'b1;
                    n_t       = '0;
                    if (r_len) begin
                        n_done = 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == IDX_LAST) begin
                        // digest delivered: ready for the next message
                        n_state   = S_IDLE;
                        n_idx     = '0;
                        cctl.init = 1'b1;
                        n_count   = '0;
                        n_final   = 1'b0;
                        n_len     = 1'b0;
                        n_done    = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/sha1md_checker.sv
// port-level checker for the sha1 message digest top level, with its bind
module sha1md_port_assert
    import sha1md_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // no new message bytes while a digest is being delivered
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while digest pending");

    a_last_is_four: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.last_word |-> o_out_item.word_index == IDX_LAST)
        else $error("last word flag on wrong index");

    // words follow in order without gaps
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_item.last_word |=>
            o_out_valid && o_out_item.word_index == 3'($past(o_out_item.word_index) + 3'd1))
        else $error("digest word sequence broken");

    a_end_of_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out_item.last_word |=> !o_out_valid)
        else $error("output valid after last word");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output changed");

endmodule

bind sha1_message_digest_top sha1md_port_assert u_sha1md_port_assert (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
